FILE: rtl/core/stb_pkg.sv
package stb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TIME_W     = 32;
  localparam int MASK_W     = 8;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_QUERY = 2'd3
  } stb_cmd_e;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_TIMEOUT = 2'd2
  } stb_run_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_DONE
  } stb_state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [2:0]        timer_id;
    logic              timer_mode;
    logic [TIME_W-1:0] delay_ticks;
  } stb_in_t;

  typedef struct packed {
    logic [MASK_W-1:0] expired_mask;
    logic [1:0]        timer_status;
  } stb_out_t;

  // control from the sequencer to the timer bank
  typedef struct packed {
    logic              start;
    logic              stop;
    logic              walk_rd;
    logic [IDX_W-1:0]  idx;
    logic              periodic;
    logic [TIME_W-1:0] delay;
  } stb_req_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    stb_run_e         status;
  } stb_rsp_t;

endpackage

FILE: rtl/core/stb_bank.sv
module stb_bank import stb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TIME_W-1:0] count_i,
  input  stb_req_t          req_i,
  output stb_rsp_t          rsp_o
);

  // {reload_period, match_time} per timer
  logic [2*TIME_W-1:0] mem [NUM_TIMERS];
  logic [2*TIME_W-1:0] rdata_q;

  stb_run_e         run_q [NUM_TIMERS];
  stb_run_e         run_d [NUM_TIMERS];
  logic             per_q [NUM_TIMERS];
  logic             per_d [NUM_TIMERS];
  logic             p_vld_q, p_vld_d;
  logic [IDX_W-1:0] p_idx_q, p_idx_d;

  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [2*TIME_W-1:0] wdata;
  logic                hit;
  logic [TIME_W-1:0]   rd_match, rd_period;

  assign rd_match  = rdata_q[TIME_W-1:0];
  assign rd_period = rdata_q[2*TIME_W-1:TIME_W];
  assign p_vld_d   = req_i.walk_rd;
  assign p_idx_d   = req_i.idx;

  always_comb begin
    run_d = run_q;
    per_d = per_q;
    we    = 1'b0;
    waddr = req_i.idx;
    wdata = {req_i.delay, count_i + req_i.delay};
    hit   = 1'b0;
    if (req_i.start) begin
      run_d[req_i.idx] = ST_RUNNING;
      per_d[req_i.idx] = req_i.periodic;
      we               = 1'b1;
    end else if (req_i.stop) begin
      run_d[req_i.idx] = ST_STOPPED;
    end
    if (p_vld_q) begin
      waddr = p_idx_q;
      wdata = {rd_period, count_i + rd_period};
      case (run_q[p_idx_q])
        ST_RUNNING: begin
          if (rd_match <= count_i) begin
            run_d[p_idx_q] = ST_TIMEOUT;
            hit            = 1'b1;
          end
        end
        ST_TIMEOUT: begin
          if (per_q[p_idx_q]) begin
            run_d[p_idx_q] = ST_RUNNING;
            we             = 1'b1;
          end else begin
            run_d[p_idx_q] = ST_STOPPED;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        run_q[i] <= ST_STOPPED;
        per_q[i] <= 1'b0;
      end
      p_vld_q <= 1'b0;
      p_idx_q <= '0;
    end else begin
      run_q   <= run_d;
      per_q   <= per_d;
      p_vld_q <= p_vld_d;
      p_idx_q <= p_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (req_i.walk_rd) begin
      rdata_q <= mem[req_i.idx];
    end
  end

  assign rsp_o.hit     = hit;
  assign rsp_o.hit_idx = p_idx_q;
  assign rsp_o.status  = run_q[req_i.idx];

endmodule

FILE: rtl/core/soft_timer_bank.sv
// Bank of software timers sharing one 32-bit tick count, advanced by each tick.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one command
// item: tick, start, stop or query. Output channel (out_valid_o /
// out_stall_i / out_data_o) returns exactly one result item per command:
// the expired mask (tick only) and the addressed timer's status.
// A tick walks the timer table one entry per cycle through the single
// match/period memory (read, compare, write back); its result is
// registered after the walk, a drain state and the final state. Start,
// stop and query skip the walk and go straight to the final state, which
// loads the output register.
// One item is worked at a time; in_stall_o is high while an item is busy.
// A finished result sits in the output register; if the receiver stalls
// and a new result is ready, the sequencer holds in its final state and
// input stays stalled until the register frees.
// Reset clears the tick count, all timer states (stopped, one-shot) and
// the output valid flag; the memory needs no clearing since an entry's value
// is used only after a start has written it.
module soft_timer_bank import stb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  stb_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output stb_out_t out_data_o
);

  stb_state_e        state_q, state_d;
  logic [TIME_W-1:0] count_q, count_d;
  logic [IDX_W-1:0]  walk_q, walk_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [IDX_W-1:0]  id_q, id_d;
  logic              id_ok_q, id_ok_d;
  logic              out_valid_q, out_valid_d;
  stb_out_t          out_q, out_d;

  logic              in_acc;
  logic              id_ok;
  stb_req_t          req;
  stb_rsp_t          rsp;

  assign in_acc = in_valid_i && !in_stall_o;
  assign id_ok  = 32'(in_data_i.timer_id) < NUM_TIMERS;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    walk_d      = walk_q;
    mask_d      = mask_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    id_ok_d     = id_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    in_stall_o  = (state_q != S_IDLE);

    req          = '0;
    req.idx      = id_q;
    req.periodic = in_data_i.timer_mode;
    req.delay    = in_data_i.delay_ticks;

    if (rsp.hit) begin
      mask_d = mask_q | (MASK_W'(1) << rsp.hit_idx);
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d   = in_data_i.command;
          id_d    = IDX_W'(in_data_i.timer_id);
          id_ok_d = id_ok;
          req.idx = IDX_W'(in_data_i.timer_id);
          if (in_data_i.command == CMD_TICK) begin
            count_d = count_q + 1'b1;
            walk_d  = '0;
            mask_d  = '0;
            state_d = S_WALK;
          end else begin
            req.start = (in_data_i.command == CMD_START) && id_ok;
            req.stop  = (in_data_i.command == CMD_STOP) && id_ok;
            state_d   = S_DONE;
          end
        end
      end
      S_WALK: begin
        req.walk_rd = 1'b1;
        req.idx     = walk_q;
        walk_d      = walk_q + 1'b1;
        if (walk_q == IDX_W'(NUM_TIMERS - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d             = 1'b1;
          out_d.expired_mask      = (cmd_q == CMD_TICK) ? mask_q : '0;
          out_d.timer_status      = id_ok_q ? rsp.status : ST_STOPPED;
          state_d                 = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      walk_q      <= '0;
      mask_q      <= '0;
      cmd_q       <= CMD_TICK;
      id_q        <= '0;
      id_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      mask_q      <= mask_d;
      cmd_q       <= cmd_d;
      id_q        <= id_d;
      id_ok_q     <= id_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  stb_bank u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .count_i (count_d),
    .req_i   (req),
    .rsp_o   (rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result appeared outside the final state");

  a_mask_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && cmd_q != CMD_TICK && (!out_valid_q || !out_stall_i))
      |-> (out_d.expired_mask == '0))
    else $error("expired mask set on a non-tick item");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.timer_status != 2'd3))
    else $error("illegal timer status");

  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && walk_q == IDX_W'(NUM_TIMERS - 1)) |=> (state_q == S_DRAIN))
    else $error("table walk did not end after the last entry");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_DRAIN) |-> in_stall_o)
    else $error("input open during table walk");

endmodule
